// ----- rtl/four_channel_audio_dma_player_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the four-channel audio DMA player
// Shared wrappers that clock on clk and stay quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_AUDIO_DMA_PLAYER_TOP_MACROS_SVH
`define FOUR_CHANNEL_AUDIO_DMA_PLAYER_TOP_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define FCADP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define FCADP_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

// ----- rtl/fcadp_pkg.sv -----
// ----------------------------------------------------------------------------
// Four-channel audio DMA player package
// Request and register codes, defaults, and the records passed between units.
// ----------------------------------------------------------------------------
package fcadp_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_CHANNEL_COUNT  = 4;
	localparam int DEF_FRAME_DIVIDE   = 162;
	localparam int DEF_CHIP_ADDR_BITS = 21;

	// Fixed field widths.
	localparam int ADDR_W = 21;
	localparam int LANE_W = 3;

	// Depth of the result queue; also the number of beats allowed in flight.
	localparam int OQ_DEPTH = 4;

	// First DMA slot position; channel n owns SLOT_BASE + 2n.
	localparam logic [7:0] SLOT_BASE = 8'h0D;

	// Request types.
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_RETURN = 2'd1;
	localparam logic [1:0] REQ_WRITE  = 2'd2;

	// Register selects.
	localparam logic [2:0] SEL_LOCATION = 3'd0;
	localparam logic [2:0] SEL_LENGTH   = 3'd1;
	localparam logic [2:0] SEL_PERIOD   = 3'd2;
	localparam logic [2:0] SEL_VOLUME   = 3'd3;
	localparam logic [2:0] SEL_DATA     = 3'd4;

	// Complete state of one channel, one entry of the state RAM.
	typedef struct packed {
		logic [ADDR_W-1:0] location;
		logic [15:0]       length;
		logic [15:0]       period;
		logic [7:0]        volume;
		logic [15:0]       data_word;
		logic [ADDR_W-1:0] run_pointer;
		logic [15:0]       run_length;
		logic [15:0]       run_period;
		logic [15:0]       period_count;
		logic [15:0]       sample_count;
		logic [15:0]       held_sample;
	} chan_rec_t;

	// Control for one pass of a channel record through the update stage.
	typedef struct packed {
		logic [1:0]        kind;
		logic [LANE_W-1:0] lane;
		logic              first;
		logic              last;
		logic              ram_op;
		logic [7:0]        hpos;
		logic [4:0]        dma_enable;
		logic              frame;
		logic [2:0]        reg_select;
		logic [20:0]       write_value;
		logic [15:0]       mem_word;
	} lane_ctl_t;

	// What one channel contributes to the tick result.
	typedef struct packed {
		logic [3:0]        irq;
		logic              fetch;
		logic [ADDR_W-1:0] fetch_addr;
		logic [1:0]        fetch_channel;
		logic [15:0]       sample;
	} lane_res_t;

	// One result beat.
	typedef struct packed {
		logic [3:0]        irq_set;
		logic              fetch_req;
		logic [ADDR_W-1:0] fetch_addr;
		logic [1:0]        fetch_channel;
		logic              frame_valid;
		logic [3:0][15:0]  samples;
	} result_t;

endpackage

// ----- rtl/fcadp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered, old data on
// a read of the address being written in the same cycle.
// ----------------------------------------------------------------------------
module fcadp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/fcadp_chan_unit.sv -----
// ----------------------------------------------------------------------------
// Channel update unit
// Applies a tick, a word return or a register write to one channel record
// and reports the interrupt, fetch and sample that the channel yields.
// ----------------------------------------------------------------------------
module fcadp_chan_unit #(
	parameter int CHIP_ADDR_BITS = fcadp_pkg::DEF_CHIP_ADDR_BITS
) (
	input  fcadp_pkg::chan_rec_t rec_in,
	input  fcadp_pkg::lane_ctl_t ctl,
	output fcadp_pkg::chan_rec_t rec_out,
	output fcadp_pkg::lane_res_t lres
);

	localparam int AW = fcadp_pkg::ADDR_W;
	localparam logic [AW-1:0] ADDR_MASK = AW'((64'd1 << CHIP_ADDR_BITS) - 64'd1);

	logic               enabled;
	logic               slot_hit;
	logic [7:0]         slot_pos;
	logic [3:0]         irq_bit;
	logic signed [7:0]  sbyte;
	logic signed [8:0]  svol;
	logic signed [16:0] prod;

	// Only the four lowest channels have enable bits.
	assign enabled = (ctl.lane < fcadp_pkg::LANE_W'(4)) && ctl.dma_enable[4]
		&& ctl.dma_enable[ctl.lane[1:0]];
	assign slot_pos = fcadp_pkg::SLOT_BASE + {4'd0, ctl.lane, 1'b0};
	assign slot_hit = enabled && (ctl.hpos == slot_pos);
	assign irq_bit  = (ctl.lane < fcadp_pkg::LANE_W'(4)) ? (4'b0001 << ctl.lane[1:0]) : 4'b0000;

	// High byte on an even sample count, low byte on an odd one, scaled by volume.
	assign sbyte = rec_in.sample_count[0] ? $signed(rec_in.data_word[7:0])
		: $signed(rec_in.data_word[15:8]);
	assign svol  = $signed({1'b0, rec_in.volume});
	assign prod  = sbyte * svol;

	always_comb begin
		rec_out = rec_in;
		lres    = '0;
		case (ctl.kind)
			fcadp_pkg::REQ_TICK: begin
				// Period counter and sample pick-up.
				if (enabled) begin
					rec_out.period_count = rec_in.period_count + 16'd1;
					if (rec_out.period_count == rec_in.run_period) begin
						rec_out.period_count = '0;
						rec_out.sample_count = rec_in.sample_count + 16'd1;
						rec_out.held_sample  = prod[15:0];
					end
				end
				lres.sample = rec_out.held_sample;
				// DMA slot: reload an empty block, then fetch after two samples.
				if (slot_hit) begin
					if (rec_out.run_length == 16'd0) begin
						rec_out.run_pointer  = rec_in.location & ADDR_MASK;
						rec_out.run_length   = rec_in.length;
						rec_out.run_period   = rec_in.period;
						rec_out.period_count = '0;
						rec_out.sample_count = 16'd2;
						lres.irq             = irq_bit;
					end
					if (rec_out.sample_count >= 16'd2) begin
						lres.fetch           = 1'b1;
						lres.fetch_addr      = rec_out.run_pointer;
						lres.fetch_channel   = ctl.lane[1:0];
						rec_out.run_length   = rec_out.run_length - 16'd1;
						rec_out.run_pointer  = (rec_out.run_pointer + AW'(2)) & ADDR_MASK;
						rec_out.sample_count = '0;
					end
				end
			end
			fcadp_pkg::REQ_RETURN: begin
				rec_out.data_word = ctl.mem_word;
			end
			fcadp_pkg::REQ_WRITE: begin
				case (ctl.reg_select)
					fcadp_pkg::SEL_LOCATION: rec_out.location  = ctl.write_value & ADDR_MASK;
					fcadp_pkg::SEL_LENGTH:   rec_out.length    = ctl.write_value[15:0];
					fcadp_pkg::SEL_PERIOD:   rec_out.period    = ctl.write_value[15:0];
					fcadp_pkg::SEL_VOLUME:   rec_out.volume    = ctl.write_value[7:0];
					fcadp_pkg::SEL_DATA:     rec_out.data_word = ctl.write_value[15:0];
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/fcadp_out_queue.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Small circular buffer of finished result beats in front of the output.
// ----------------------------------------------------------------------------
module fcadp_out_queue #(
	parameter int DEPTH = fcadp_pkg::OQ_DEPTH,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fcadp_pkg::result_t push_data,
	input  logic               pop,
	output logic               head_valid,
	output fcadp_pkg::result_t head_data,
	output logic [CW-1:0]      count
);

	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	fcadp_pkg::result_t entry_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;

	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];
	assign count      = count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/four_channel_audio_dma_player_top.sv -----
// ----------------------------------------------------------------------------
// Four-channel audio DMA player, top level
// A tick occupies the issue stage while it walks its channels, one channel record
// read per cycle from the state RAM; a write or word return issues a single record.
// Each beat's result passes the update stage and enters the result queue, whose
// head is the output; input stalls with four beats in flight.
// Reset clears per-entry valid bits at once so every record reads as zero.
// ----------------------------------------------------------------------------
`include "four_channel_audio_dma_player_top_macros.svh"

module four_channel_audio_dma_player_top #(
	parameter int CHANNEL_COUNT  = fcadp_pkg::DEF_CHANNEL_COUNT,
	parameter int FRAME_DIVIDE   = fcadp_pkg::DEF_FRAME_DIVIDE,
	parameter int CHIP_ADDR_BITS = fcadp_pkg::DEF_CHIP_ADDR_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         req_type,
	input  logic [1:0]         channel,
	input  logic [2:0]         reg_select,
	input  logic [20:0]        write_value,
	input  logic [7:0]         hpos,
	input  logic [4:0]         dma_enable,
	input  logic [15:0]        mem_word,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [3:0]         irq_set,
	output logic               fetch_req,
	output logic [20:0]        fetch_addr,
	output logic [1:0]         fetch_channel,
	output logic               frame_valid,
	output logic signed [15:0] sample_ch0,
	output logic signed [15:0] sample_ch1,
	output logic signed [15:0] sample_ch2,
	output logic signed [15:0] sample_ch3
);

	localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int LANE_W   = fcadp_pkg::LANE_W;
	localparam int REC_W    = $bits(fcadp_pkg::chan_rec_t);
	localparam int OQ_W     = $clog2(fcadp_pkg::OQ_DEPTH + 1);
	localparam logic [CH_IDX_W-1:0] LAST_IDX  = CH_IDX_W'(CHANNEL_COUNT - 1);
	localparam logic [7:0]          FRAME_TOP = 8'(FRAME_DIVIDE);
	localparam logic [OQ_W-1:0]     OQ_FULL   = OQ_W'(fcadp_pkg::OQ_DEPTH);

	logic                  accept;
	logic                  pop;
	logic                  ch_present;
	logic [7:0]            frame_nxt;
	logic                  frame_hit;

	// Tick sequencer.
	logic                  seq_busy_q;
	logic [CH_IDX_W-1:0]   seq_ch_q;
	logic [7:0]            tick_hpos_q;
	logic [4:0]            tick_en_q;
	logic                  tick_frame_q;
	logic [7:0]            frame_q;
	logic [OQ_W-1:0]       outstanding_q;

	// Issue stage.
	logic                  iss_valid;
	fcadp_pkg::lane_ctl_t  iss_ctl;

	// State RAM and bypass.
	logic                  ram_re;
	logic [CH_IDX_W-1:0]   ram_raddr;
	logic                  ram_we;
	logic [CH_IDX_W-1:0]   ram_waddr;
	logic [REC_W-1:0]      ram_rdata;
	logic [CHANNEL_COUNT-1:0] valid_q;

	// Update stage.
	logic                  valid_s1;
	fcadp_pkg::lane_ctl_t  ctl_s1;
	logic                  vld_s1;
	logic                  byp_hit_s1;
	fcadp_pkg::chan_rec_t  byp_data_s1;
	fcadp_pkg::chan_rec_t  rec_in;
	fcadp_pkg::chan_rec_t  rec_out;
	fcadp_pkg::lane_res_t  lres;

	// Result assembly.
	fcadp_pkg::result_t    acc_q;
	fcadp_pkg::result_t    merged;
	fcadp_pkg::result_t    push_data;
	logic                  push;
	fcadp_pkg::result_t    head;
	logic [OQ_W-1:0]       q_count;

	// Input handshake: hold off while a tick walks its channels or the queue is booked.
	assign item_stall = seq_busy_q || (outstanding_q == OQ_FULL);
	assign accept     = item_valid && !item_stall;
	assign pop        = result_valid && !result_stall;
	assign ch_present = (int'(channel) < CHANNEL_COUNT);
	assign frame_nxt  = frame_q + 8'd1;
	assign frame_hit  = (frame_nxt == FRAME_TOP);

	// Issue one channel record per cycle while a tick walks its channels or an item is accepted.
	always_comb begin
		iss_valid = 1'b0;
		iss_ctl   = '0;
		if (seq_busy_q) begin
			iss_valid          = 1'b1;
			iss_ctl.kind       = fcadp_pkg::REQ_TICK;
			iss_ctl.lane       = LANE_W'(seq_ch_q);
			iss_ctl.last       = (seq_ch_q == LAST_IDX);
			iss_ctl.ram_op     = 1'b1;
			iss_ctl.hpos       = tick_hpos_q;
			iss_ctl.dma_enable = tick_en_q;
			iss_ctl.frame      = tick_frame_q;
		end else if (accept) begin
			iss_valid           = 1'b1;
			iss_ctl.kind        = req_type;
			iss_ctl.hpos        = hpos;
			iss_ctl.dma_enable  = dma_enable;
			iss_ctl.frame       = frame_hit;
			iss_ctl.reg_select  = reg_select;
			iss_ctl.write_value = write_value;
			iss_ctl.mem_word    = mem_word;
			iss_ctl.first       = 1'b1;
			case (req_type)
				fcadp_pkg::REQ_TICK: begin
					iss_ctl.lane   = '0;
					iss_ctl.last   = (CHANNEL_COUNT == 1);
					iss_ctl.ram_op = 1'b1;
				end
				fcadp_pkg::REQ_RETURN, fcadp_pkg::REQ_WRITE: begin
					iss_ctl.lane   = LANE_W'(channel);
					iss_ctl.last   = 1'b1;
					iss_ctl.ram_op = ch_present;
				end
				default: begin
					iss_ctl.last   = 1'b1;
					iss_ctl.ram_op = 1'b0;
				end
			endcase
		end
	end

	// Sequencer, frame divider and credit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_busy_q    <= 1'b0;
			seq_ch_q      <= '0;
			frame_q       <= '0;
			outstanding_q <= '0;
		end else begin
			if (seq_busy_q) begin
				if (seq_ch_q == LAST_IDX) begin
					seq_busy_q <= 1'b0;
				end else begin
					seq_ch_q <= seq_ch_q + CH_IDX_W'(1);
				end
			end else if (accept && (req_type == fcadp_pkg::REQ_TICK)) begin
				seq_busy_q <= (CHANNEL_COUNT > 1);
				seq_ch_q   <= CH_IDX_W'(1);
			end
			if (accept && (req_type == fcadp_pkg::REQ_TICK)) begin
				frame_q <= frame_hit ? 8'd0 : frame_nxt;
			end
			case ({accept, pop})
				2'b10:   outstanding_q <= outstanding_q + OQ_W'(1);
				2'b01:   outstanding_q <= outstanding_q - OQ_W'(1);
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	// Tick fields held for the remaining channels.
	always_ff @(posedge clk) begin
		if (accept && (req_type == fcadp_pkg::REQ_TICK)) begin
			tick_hpos_q  <= hpos;
			tick_en_q    <= dma_enable;
			tick_frame_q <= frame_hit;
		end
	end

	// State RAM ports.
	assign ram_re    = iss_valid && iss_ctl.ram_op;
	assign ram_raddr = CH_IDX_W'(iss_ctl.lane);
	assign ram_we    = valid_s1 && ctl_s1.ram_op;
	assign ram_waddr = CH_IDX_W'(ctl_s1.lane);

	fcadp_ram #(
		.WIDTH (REC_W),
		.DEPTH (CHANNEL_COUNT)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rec_out),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Entry valid bits and the update-stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_s1   <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			valid_s1   <= iss_valid;
			byp_hit_s1 <= ram_re && ram_we && (ram_waddr == ram_raddr);
		end
	end

	// Stage payload; a read that meets a write to its entry takes the write data.
	always_ff @(posedge clk) begin
		if (iss_valid) begin
			ctl_s1 <= iss_ctl;
		end
		if (ram_re) begin
			vld_s1      <= valid_q[ram_raddr];
			byp_data_s1 <= rec_out;
		end
	end

	assign rec_in = byp_hit_s1 ? byp_data_s1
		: (vld_s1 ? fcadp_pkg::chan_rec_t'(ram_rdata) : '0);

	fcadp_chan_unit #(
		.CHIP_ADDR_BITS (CHIP_ADDR_BITS)
	) u_chan_unit (
		.rec_in  (rec_in),
		.ctl     (ctl_s1),
		.rec_out (rec_out),
		.lres    (lres)
	);

	// Merge this channel into the tick result.
	always_comb begin
		merged         = ctl_s1.first ? '0 : acc_q;
		merged.irq_set = merged.irq_set | lres.irq;
		if (lres.fetch) begin
			merged.fetch_req     = 1'b1;
			merged.fetch_addr    = lres.fetch_addr;
			merged.fetch_channel = lres.fetch_channel;
		end
		if (ctl_s1.lane < LANE_W'(4)) begin
			merged.samples[ctl_s1.lane[1:0]] = lres.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= merged;
		end
	end

	// Finished beat: samples only on a frame, absent channels read zero.
	always_comb begin
		push      = valid_s1 && ctl_s1.last;
		push_data = '0;
		if (ctl_s1.kind == fcadp_pkg::REQ_TICK) begin
			push_data.irq_set       = merged.irq_set;
			push_data.fetch_req     = merged.fetch_req;
			push_data.fetch_addr    = merged.fetch_addr;
			push_data.fetch_channel = merged.fetch_channel;
			push_data.frame_valid   = ctl_s1.frame;
			for (int j = 0; j < 4; j++) begin
				if (ctl_s1.frame && (j < CHANNEL_COUNT)) begin
					push_data.samples[j] = merged.samples[j];
				end
			end
		end
	end

	fcadp_out_queue #(
		.DEPTH (fcadp_pkg::OQ_DEPTH)
	) u_out_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (result_valid),
		.head_data  (head),
		.count      (q_count)
	);

	// Output fields.
	assign irq_set       = head.irq_set;
	assign fetch_req     = head.fetch_req;
	assign fetch_addr    = head.fetch_addr;
	assign fetch_channel = head.fetch_channel;
	assign frame_valid   = head.frame_valid;
	assign sample_ch0    = $signed(head.samples[0]);
	assign sample_ch1    = $signed(head.samples[1]);
	assign sample_ch2    = $signed(head.samples[2]);
	assign sample_ch3    = $signed(head.samples[3]);

	// Checks.
	`FCADP_ASSERT_ALWAYS(a_credit_bound, outstanding_q <= OQ_FULL, "too many beats in flight")
	`FCADP_ASSERT_ALWAYS(a_queue_vs_credit, q_count <= outstanding_q, "queue holds unbooked beat")
	`FCADP_ASSERT_IMPLIES(a_idle_fetch, result_valid && !fetch_req, fetch_addr == 21'd0 && fetch_channel == 2'd0, "fetch fields set without fetch")
	`FCADP_ASSERT_IMPLIES(a_idle_frame, result_valid && !frame_valid, sample_ch0 == 16'sd0 && sample_ch1 == 16'sd0 && sample_ch2 == 16'sd0 && sample_ch3 == 16'sd0, "samples set without frame")

endmodule
